FILE: sv/sch_pkg.sv
package sch_pkg;

  // Radius field and its square
  localparam int RADIUS_BITS = 15;
  localparam int R2_BITS     = 2 * RADIUS_BITS;

  // Register stages from input transfer to output register
  localparam int PIPE_DEPTH  = 7;

endpackage

FILE: sv/sch_if.sv
interface sch_in_if import sch_pkg::*; #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] centre_x;
  logic signed [COORD_BITS-1:0] centre_y;
  logic [RADIUS_BITS-1:0]       radius;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    output centre_x, centre_y, radius,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    input  centre_x, centre_y, radius,
    output ready
  );
endinterface

interface sch_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

FILE: sv/segment_circle_hit_test_unit.sv
// Segment/circle hit test, seven-stage pipeline.
// Each result passes stages 1 to 7 in order and waits in the stage-7 register during any output stall.
// Throughput: one item per cycle while the output is not stalled; empty stages fill while it is stalled.
// The widest products (squared line distance, norm times r^2) are split into
// half-width partial products over two stages.
// Reset (rst, synchronous, active high) empties the pipeline; no other state.
module segment_circle_hit_test_unit import sch_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  sch_in_if.sink    item,
  sch_out_if.source result
);

  localparam int DW   = COORD_BITS + 1;            // coordinate difference
  localparam int PW   = 2 * DW;                    // product of two differences
  localparam int SW   = PW + 1;                    // sum of two products
  localparam int BW   = ((COORD_BITS + 2 > RADIUS_BITS) ? COORD_BITS + 2 : RADIUS_BITS) + 1;
  localparam int BSQW = 2 * BW;
  localparam int CW   = (BSQW > R2_BITS) ? BSQW : R2_BITS;
  localparam int AW   = PW;                        // |d| and a^2+b^2
  localparam int HW   = AW / 2;                    // half for partial products
  localparam int LW   = 2 * AW;
  localparam int RW   = AW + R2_BITS;
  localparam int CMPW = (LW > RW) ? LW : RW;

  typedef struct packed {
    logic rej;
    logic in_circle;
    logic dot_ok;
  } flags_t;

  // Stage handshake: a stage loads when empty or when the next one moves
  logic [PIPE_DEPTH:1] v;
  logic [PIPE_DEPTH:1] en;

  always_comb begin
    en[PIPE_DEPTH] = !v[PIPE_DEPTH] || result.ready;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= item.valid;
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign item.ready   = en[1];
  assign result.valid = v[PIPE_DEPTH];

  // ---------------- Stage 1: differences and line coefficients
  logic signed [DW-1:0] s1_ex, s1_ey, s1_dx1, s1_dy1, s1_dx2, s1_dy2, s1_a, s1_b;
  logic signed [DW-1:0] a_next, b_next, ex_next;
  logic [RADIUS_BITS-1:0] s1_r;

  assign ex_next = DW'(item.seg_end_x) - DW'(item.seg_start_x);

  // vertical first, then horizontal, then the general line
  always_comb begin
    if (item.seg_start_x == item.seg_end_x) begin
      a_next = DW'(1);
      b_next = '0;
    end else if (item.seg_start_y == item.seg_end_y) begin
      a_next = '0;
      b_next = DW'(1);
    end else begin
      a_next = DW'(item.seg_start_y) - DW'(item.seg_end_y);
      b_next = ex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ex  <= ex_next;
      s1_ey  <= DW'(item.seg_end_y) - DW'(item.seg_start_y);
      s1_dx1 <= DW'(item.centre_x) - DW'(item.seg_start_x);
      s1_dy1 <= DW'(item.centre_y) - DW'(item.seg_start_y);
      s1_dx2 <= DW'(item.centre_x) - DW'(item.seg_end_x);
      s1_dy2 <= DW'(item.centre_y) - DW'(item.seg_end_y);
      s1_a   <= a_next;
      s1_b   <= b_next;
      s1_r   <= item.radius;
    end
  end

  // ---------------- Stage 2: products and distance bound
  logic signed [PW-1:0] s2_sq_dx1, s2_sq_dy1, s2_sq_dx2, s2_sq_dy2;
  logic signed [PW-1:0] s2_pa, s2_pb, s2_aa, s2_bb;
  logic signed [PW-1:0] s2_p1x, s2_p1y, s2_p2x, s2_p2y;
  logic [R2_BITS-1:0]   s2_r2;
  logic [BW-1:0]        s2_bound;
  logic [DW-1:0]        abs_ex, abs_ey;

  assign abs_ex = s1_ex[DW-1] ? DW'(-s1_ex) : DW'(s1_ex);
  assign abs_ey = s1_ey[DW-1] ? DW'(-s1_ey) : DW'(s1_ey);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sq_dx1 <= s1_dx1 * s1_dx1;
      s2_sq_dy1 <= s1_dy1 * s1_dy1;
      s2_sq_dx2 <= s1_dx2 * s1_dx2;
      s2_sq_dy2 <= s1_dy2 * s1_dy2;
      s2_pa     <= s1_a * s1_dx1;
      s2_pb     <= s1_b * s1_dy1;
      s2_aa     <= s1_a * s1_a;
      s2_bb     <= s1_b * s1_b;
      s2_p1x    <= s1_dx1 * s1_ex;
      s2_p1y    <= s1_dy1 * s1_ey;
      s2_p2x    <= s1_dx2 * s1_ex;
      s2_p2y    <= s1_dy2 * s1_ey;
      s2_r2     <= R2_BITS'(s1_r) * R2_BITS'(s1_r);
      s2_bound  <= BW'(abs_ex) + BW'(abs_ey) + BW'(s1_r);
    end
  end

  // ---------------- Stage 3: sums and squared bound
  logic [BSQW-1:0]      s3_bsq;
  logic signed [SW-1:0] s3_d1sq, s3_d2sq, s3_d, s3_s, s3_dot1, s3_dot2n;
  logic [R2_BITS-1:0]   s3_r2;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_bsq   <= BSQW'(s2_bound) * BSQW'(s2_bound);
      s3_d1sq  <= SW'(s2_sq_dx1) + SW'(s2_sq_dy1);
      s3_d2sq  <= SW'(s2_sq_dx2) + SW'(s2_sq_dy2);
      s3_d     <= SW'(s2_pa) + SW'(s2_pb);
      s3_s     <= SW'(s2_aa) + SW'(s2_bb);
      s3_dot1  <= SW'(s2_p1x) + SW'(s2_p1y);
      // second dot product, negated: (c-e2).(e2-e1)
      s3_dot2n <= SW'(s2_p2x) + SW'(s2_p2y);
      s3_r2    <= s2_r2;
    end
  end

  // ---------------- Stage 4: early tests, |d|
  flags_t             s4_flags, flags_next;
  logic [AW-1:0]      s4_dabs, s4_s;
  logic [R2_BITS-1:0] s4_r2;
  logic [CW-1:0]      d1sq_u, d2sq_u;

  assign d1sq_u = CW'(s3_d1sq[SW-2:0]);
  assign d2sq_u = CW'(s3_d2sq[SW-2:0]);

  always_comb begin
    flags_next.rej       = d1sq_u > CW'(s3_bsq);
    flags_next.in_circle = (d1sq_u < CW'(s3_r2)) || (d2sq_u < CW'(s3_r2));
    flags_next.dot_ok    = !s3_dot1[SW-1] && (s3_dot1 != '0) && s3_dot2n[SW-1];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_flags <= flags_next;
      s4_dabs  <= s3_d[SW-1] ? AW'(-s3_d) : AW'(s3_d);
      s4_s     <= s3_s[AW-1:0];
      s4_r2    <= s3_r2;
    end
  end

  // ---------------- Stage 5: half-width partial products
  flags_t                   s5_flags;
  logic [AW-1:0]            s5_hh, s5_hl, s5_ll;
  logic [HW+R2_BITS-1:0]    s5_sh, s5_sl;
  logic [HW-1:0]            dh, dl, sh, sl;

  assign dh = s4_dabs[AW-1:HW];
  assign dl = s4_dabs[HW-1:0];
  assign sh = s4_s[AW-1:HW];
  assign sl = s4_s[HW-1:0];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_flags <= s4_flags;
      s5_hh    <= AW'(dh) * AW'(dh);
      s5_hl    <= AW'(dh) * AW'(dl);
      s5_ll    <= AW'(dl) * AW'(dl);
      s5_sh    <= (HW + R2_BITS)'(sh) * (HW + R2_BITS)'(s4_r2);
      s5_sl    <= (HW + R2_BITS)'(sl) * (HW + R2_BITS)'(s4_r2);
    end
  end

  // ---------------- Stage 6: assemble d^2 and (a^2+b^2)*r^2
  flags_t          s6_flags;
  logic [CMPW-1:0] s6_lhs, s6_rhs;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_flags <= s5_flags;
      s6_lhs   <= (CMPW'(s5_hh) << (2 * HW)) + (CMPW'(s5_hl) << (HW + 1)) + CMPW'(s5_ll);
      s6_rhs   <= (CMPW'(s5_sh) << HW) + CMPW'(s5_sl);
    end
  end

  // ---------------- Stage 7: final decision, output register
  logic s7_hit;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_hit <= !s6_flags.rej &&
                (s6_flags.in_circle || (!(s6_lhs > s6_rhs) && s6_flags.dot_ok));
    end
  end

  assign result.hit = s7_hit;

endmodule

FILE: sv/sch_checker.sv
module sch_checker import sch_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // Items accepted but not yet delivered
  logic [$clog2(PIPE_DEPTH+1)-1:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      unique case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_hold_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("result changed while stalled");

  // pipeline takes input whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // no result without a pending item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("result without accepted item");

  // never more in flight than pipeline stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= PIPE_DEPTH)
    else $error("too many items in flight");

endmodule

bind segment_circle_hit_test_unit sch_checker u_sch_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_hit   (result.hit)
);
